/* rtl/core/psev_pkg.sv */
`default_nettype none
package psev_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	// token opcodes
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_LONE    = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_DIVZERO = 3'd4;
	localparam logic [2:0] ST_SAT     = 3'd5;

	localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] operand_value;
	} token_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic [DEPTH_W-1:0] stack_depth;
		logic [2:0]         status;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [31:0]       wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

/* rtl/core/psev_stack_mem.sv */
`default_nettype none
module psev_stack_mem (
	input  wire logic              clk,
	input  wire psev_pkg::mem_req_t req,
	output logic [31:0]            rdata
);
	import psev_pkg::*;

	logic [31:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// registered read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/psev_div.sv */
`default_nettype none
module psev_div #(
	parameter int FRAC_BITS = psev_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [31:0]           dividend_mag,
	input  wire logic [31:0]           divisor_mag,
	output logic                       done,
	output logic [32+FRAC_BITS-1:0]    quotient
);
	import psev_pkg::*;

	localparam int N = 32 + FRAC_BITS;
	localparam int CNT_W = $clog2(N + 1);

	logic [31:0]      rem_q;
	logic [31:0]      dvs_q;
	logic [N-1:0]     quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [32:0]      rem_sh;
	logic             fits;
	logic [32:0]      rem_sub;

	// restoring step, one quotient bit per cycle
	assign rem_sh  = {rem_q, quo_q[N-1]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(N);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor_mag;
			quo_q <= N'(dividend_mag) << FRAC_BITS;
		end else if (run_q) begin
			rem_q <= fits ? rem_sub[31:0] : rem_sh[31:0];
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

/* rtl/core/postfix_stack_evaluator.sv */
// channel  | beat     | handshake                  | direction
// token    | token_t  | token_valid / token_stall  | in
// result   | result_t | result_valid / result_stall| out
//
// one token at a time; the states between the token beat and the result beat:
//   push, one-entry operators, errors: none; add, subtract: stack read; multiply: read, product
//   divide: stack read, then the one-bit-per-cycle restoring divider
// operands come from a single-port-read stack memory with a registered read port
// arst_n clears the depth, the sequencer and the result valid; stack entries are not cleared
// token_stall is high whenever the sequencer is busy; a stalled result holds in its register
`default_nettype none
module postfix_stack_evaluator #(
	parameter int FRAC_BITS = psev_pkg::FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             token_valid,
	output logic                  token_stall,
	input  wire psev_pkg::token_t token,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output psev_pkg::result_t     result
);
	import psev_pkg::*;

	localparam int N_DIV = 32 + FRAC_BITS;

	// sequencer and stack bookkeeping
	state_t             state_q, state_d;
	logic [DEPTH_W-1:0] count_q, count_d;
	logic [31:0]        top_q, top_d;      // cached copy of the top entry
	logic [2:0]         status_q, status_d;
	logic [2:0]         op_q, op_d;
	logic [31:0]        newer_q, newer_d;
	logic               neg_q, neg_d;
	logic signed [63:0] prod_s1;

	mem_req_t           mem_req;
	logic [31:0]        mem_rdata;

	logic               div_start;
	logic               div_done;
	logic [N_DIV-1:0]   div_quo;

	logic               accept;
	logic               res_load;
	logic               res_valid_q;
	result_t            res_q;

	// finishing a binary operator: write back, pop one
	logic               fin;
	logic [32:0]        fin_res;           // {saturated, value}

	logic signed [63:0] older_w, newer_w, top_w;
	logic               q_hi_zero, q_is_min;
	logic [DEPTH_W-1:0] below_top;

	function automatic logic [32:0] sat_wide(input logic [63:0] v);
		if (v[63:31] != {33{v[63]}}) begin
			return {1'b1, (v[63] ? Q_MIN : Q_MAX)};
		end
		return {1'b0, v[31:0]};
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	assign accept    = token_valid && !token_stall;
	assign older_w   = 64'($signed(mem_rdata));
	assign newer_w   = 64'($signed(newer_q));
	assign top_w     = 64'($signed(top_q));
	assign below_top = count_q - DEPTH_W'(2);

	// quotient range: positive fits below 2^31, negative may reach exactly 2^31
	assign q_hi_zero = div_quo[N_DIV-1:31] == '0;
	assign q_is_min  = (div_quo[N_DIV-1:31] == (N_DIV-31)'(1)) && (div_quo[30:0] == '0);

	psev_stack_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	psev_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (div_start),
		.dividend_mag (mag32(mem_rdata)),
		.divisor_mag  (mag32(newer_q)),
		.done         (div_done),
		.quotient     (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q    <= top_d;
		status_q <= status_d;
		op_q     <= op_d;
		newer_q  <= newer_d;
		neg_q    <= neg_d;
		// one signed 32x32 product, rounded and clamped in the next state
		if (state_q == S_READ) begin
			prod_s1 <= $signed(mem_rdata) * $signed(newer_q);
		end
	end

	// next state and datapath control
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		top_d     = top_q;
		status_d  = status_q;
		op_d      = op_q;
		newer_d   = newer_q;
		neg_d     = neg_q;
		mem_req   = '0;
		div_start = 1'b0;
		res_load  = 1'b0;
		fin       = 1'b0;
		fin_res   = '0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_d = ST_OK;
					state_d  = S_DONE;
					case (token.opcode)
						OP_PUSH: begin
							if (count_q == DEPTH_W'(STACK_DEPTH)) begin
								status_d = ST_FULL;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = count_q[ADDR_W-1:0];
								mem_req.wdata = token.operand_value;
								top_d         = token.operand_value;
								count_d       = count_q + DEPTH_W'(1);
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else if (count_q == DEPTH_W'(1)) begin
								// lone operand: unary forms
								case (token.opcode)
									OP_SUB: begin
										fin_res       = sat_wide(64'd0 - top_w);
										mem_req.we    = 1'b1;
										mem_req.waddr = '0;
										mem_req.wdata = fin_res[31:0];
										top_d         = fin_res[31:0];
										status_d      = fin_res[32] ? ST_SAT : ST_OK;
									end
									OP_MUL: begin
										mem_req.we    = 1'b1;
										mem_req.waddr = '0;
										mem_req.wdata = '0;
										top_d         = '0;
									end
									OP_DIV: begin
										status_d = ST_LONE;
									end
									default: begin
									end
								endcase
							end else if (token.opcode == OP_DIV && top_q == '0) begin
								status_d = ST_DIVZERO;
							end else begin
								mem_req.re    = 1'b1;
								mem_req.raddr = below_top[ADDR_W-1:0];
								op_d          = token.opcode;
								newer_d       = top_q;
								state_d       = S_READ;
							end
						end
						default: begin
							// unused opcodes leave the stack alone
						end
					endcase
				end
			end
			S_READ: begin
				case (op_q)
					OP_ADD: begin
						fin     = 1'b1;
						fin_res = sat_wide(older_w + newer_w);
					end
					OP_SUB: begin
						fin     = 1'b1;
						fin_res = sat_wide(older_w - newer_w);
					end
					OP_MUL: begin
						state_d = S_MUL;
					end
					OP_DIV: begin
						div_start = 1'b1;
						neg_d     = mem_rdata[31] ^ newer_q[31];
						state_d   = S_DIV;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_MUL: begin
				// arithmetic shift rounds toward minus infinity
				fin     = 1'b1;
				fin_res = sat_wide(prod_s1 >>> FRAC_BITS);
			end
			S_DIV: begin
				if (div_done) begin
					fin = 1'b1;
					if (!neg_q) begin
						fin_res = q_hi_zero ? {1'b0, div_quo[31:0]} : {1'b1, Q_MAX};
					end else if (q_hi_zero || q_is_min) begin
						fin_res = {1'b0, 32'd0 - div_quo[31:0]};
					end else begin
						fin_res = {1'b1, Q_MIN};
					end
				end
			end
			S_DONE: begin
				if (!res_valid_q || !result_stall) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// each write lands before the next token is accepted, so a later read never meets it;
		// no forwarding is needed here
		if (fin) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = below_top[ADDR_W-1:0];
			mem_req.wdata = fin_res[31:0];
			top_d         = fin_res[31:0];
			count_d       = count_q - DEPTH_W'(1);
			status_d      = fin_res[32] ? ST_SAT : ST_OK;
			state_d       = S_DONE;
		end
	end

	assign token_stall = state_q != S_IDLE;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.top_value   <= (count_q != '0) ? top_q : '0;
			res_q.stack_depth <= count_q;
			res_q.status      <= status_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// a push that fits grows the stack by exactly one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && token.opcode == OP_PUSH && count_q != DEPTH_W'(STACK_DEPTH)
		|=> count_q == $past(count_q) + DEPTH_W'(1))
		else $error("push did not grow the stack");

	// the divider finishes only while the sequencer waits for it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	// a new result beat comes only from the result state
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result beat raised outside the result state");

	// reported depth stays within the stack
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.stack_depth <= DEPTH_W'(STACK_DEPTH))
		else $error("reported depth beyond the stack");

endmodule
`default_nettype wire

/* verif/postfix_stack_evaluator_test.sv */
`timescale 1ns / 1ps
module postfix_stack_evaluator_test;
	import psev_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	// cycles with no beat on either channel before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	// slowest token (divide) plus margin, waited out after the last result
	localparam int SETTLE_CYCLES = 60 + FRAC;
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	// opcodes the block does not decode
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	// predicts each result beat from the token stream and checks the block against it
	class rpn_scoreboard;
		logic signed [31:0] operand_stack [STACK_DEPTH];
		int unsigned        depth = 0;
		result_t            predicted_results [$];
		int unsigned        fail_count = 0;

		// clamp to the signed 32-bit range, flagging saturation
		function logic [31:0] clamp_q(input longint v, inout logic [2:0] st);
			if (v > SAT_HI) begin
				st = ST_SAT;
				return Q_MAX;
			end
			if (v < SAT_LO) begin
				st = ST_SAT;
				return Q_MIN;
			end
			return v[31:0];
		endfunction

		// evaluate one accepted token beat and queue the result it should produce
		function void note_token(input token_t t);
			logic [2:0] st;
			longint     older, newer, r, mag_o, mag_n;
			bit         commit;
			result_t    res;
			st = ST_OK;
			r = 0;
			case (t.opcode)
			OP_PUSH: begin
				if (depth >= STACK_DEPTH)
					st = ST_FULL;
				else begin
					operand_stack[depth] = t.operand_value;
					depth++;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (depth == 0)
					st = ST_EMPTY;
				else if (depth == 1) begin
					// lone operand: add keeps it, subtract negates, multiply zeroes, divide flags it
					if (t.opcode == OP_SUB)
						operand_stack[0] = clamp_q(-longint'(operand_stack[0]), st);
					else if (t.opcode == OP_MUL)
						operand_stack[0] = '0;
					else if (t.opcode == OP_DIV)
						st = ST_LONE;
				end else begin
					newer = longint'(operand_stack[depth-1]);
					older = longint'(operand_stack[depth-2]);
					commit = 1'b1;
					case (t.opcode)
					OP_ADD: r = older + newer;
					OP_SUB: r = older - newer;
					// arithmetic shift floors, i.e. rounds toward minus infinity
					OP_MUL: r = (older * newer) >>> FRAC;
					default: begin
						if (newer == 0) begin
							st = ST_DIVZERO;
							commit = 1'b0;
						end else begin
							mag_o = (older < 0) ? -older : older;
							mag_n = (newer < 0) ? -newer : newer;
							r = (mag_o << FRAC) / mag_n;
							if ((older < 0) != (newer < 0))
								r = -r;
						end
					end
					endcase
					if (commit) begin
						operand_stack[depth-2] = clamp_q(r, st);
						depth--;
					end
				end
			end
			default: ;
			endcase
			res.top_value = (depth != 0) ? operand_stack[depth-1] : '0;
			res.stack_depth = DEPTH_W'(depth);
			res.status = st;
			predicted_results.push_back(res);
		endfunction

		// compare one accepted result beat with the oldest prediction
		function void check_result(input result_t got);
			result_t want;
			if (predicted_results.size() == 0) begin
				$error("result beat with no token pending: top_value %0d", got.top_value);
				fail_count++;
				return;
			end
			want = predicted_results.pop_front();
			if (got.top_value !== want.top_value) begin
				$error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
				fail_count++;
			end
			if (got.stack_depth !== want.stack_depth) begin
				$error("stack_depth: expected %0d, got %0d", want.stack_depth, got.stack_depth);
				fail_count++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fail_count++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    token_valid = 1'b0;
	logic    token_stall;
	token_t  token = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	rpn_scoreboard sb = new;
	// random gaps and stalls on both channels; cleared for the last segment
	bit idling_on = 1'b1;

	postfix_stack_evaluator #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token(token),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// drive one token beat; returns after the edge that accepts it
	task automatic send_token(input logic [2:0] opcode, input logic signed [31:0] value);
		token_t t;
		t.opcode = opcode;
		t.operand_value = value;
		// occasional sender gap with token_valid low
		if (idling_on && $urandom_range(0, 4) == 0) begin
			token_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		token_valid <= 1'b1;
		token <= t;
		@(posedge clk);
		while (token_stall) @(posedge clk);
		sb.note_token(t);
	endtask

	// hold the sender back until every predicted result has come out
	task automatic drain_results();
		token_valid <= 1'b0;
		while (sb.predicted_results.size() != 0) @(posedge clk);
	endtask

	// operand mix: zero and the extremes often, small whole and fractional values, raw bits
	function automatic logic signed [31:0] pick_operand();
		int whole;
		case ($urandom_range(0, 7))
		0: return '0;
		1: return Q_MAX;
		2: return Q_MIN;
		3, 4: begin
			whole = $urandom_range(0, 16);
			whole = whole - 8;
			return whole * (1 << FRAC);
		end
		5: begin
			// within +/- 4.0
			whole = $urandom_range(0, 1 << (FRAC + 3));
			whole = whole - (1 << (FRAC + 2));
			return whole;
		end
		default: return $urandom;
		endcase
	endfunction

	// random token stream; push_pct steers the stack toward full, balanced or empty
	task automatic run_segment(input int unsigned count, input int unsigned push_pct);
		int unsigned pick;
		logic [2:0]  op;
		for (int unsigned i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
			else if (pick < 3 + push_pct || (sb.depth < 2 && pick < 60))
				op = OP_PUSH;
			else
				op = 3'($urandom_range(OP_ADD, OP_DIV));
			send_token(op, pick_operand());
		end
	endtask

	// result side: check every accepted beat, stall in random bursts
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				sb.check_result(result);
			if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				result_stall <= 1'b1;
			end else
				result_stall <= 1'b0;
		end
	end

	// hang detector: cycles in a row with no beat on either channel
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if ((token_valid && !token_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// operators on an empty stack
		send_token(OP_ADD, '0);
		send_token(OP_SUB, '0);
		send_token(OP_MUL, '0);
		send_token(OP_DIV, '0);
		// lone operand cases; negating the most negative value saturates
		send_token(OP_PUSH, Q_MIN);
		send_token(OP_SUB, '0);
		send_token(OP_ADD, '0);
		send_token(OP_DIV, '0);
		send_token(OP_MUL, '0);
		// divide by zero leaves both entries
		send_token(OP_PUSH, '0);
		send_token(OP_DIV, Q_MAX);
		// positive overflow on add, subtract and divide
		send_token(OP_PUSH, Q_MAX);
		send_token(OP_PUSH, Q_MAX);
		send_token(OP_ADD, '0);
		send_token(OP_PUSH, Q_MIN);
		send_token(OP_SUB, '0);
		send_token(OP_PUSH, 32'sd1);
		send_token(OP_DIV, '0);
		// negative product rounds down, quotient truncates
		send_token(OP_PUSH, -32'sd1);
		send_token(OP_MUL, '0);
		send_token(OP_PUSH, -32'sd196608);
		send_token(OP_DIV, '0);
		// undecoded opcodes change nothing
		send_token(OP_SPARE_FIRST, Q_MIN);
		send_token(OP_SPARE_LAST, Q_MAX);
		// negative overflow on add
		send_token(OP_PUSH, Q_MIN);
		send_token(OP_PUSH, Q_MIN);
		send_token(OP_ADD, '0);
		drain_results();

		// fill the stack and push against the full mark
		run_segment(300, 70);
		drain_results();
		// expression-shaped, depth wandering in the middle
		run_segment(400, 45);
		drain_results();
		// pop-heavy to run the stack dry
		run_segment(200, 20);
		drain_results();
		// back-to-back beats, no gaps or stalls
		idling_on = 1'b0;
		run_segment(250, 45);
		drain_results();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.predicted_results.size() != 0) begin
			$error("%0d result beats never arrived", sb.predicted_results.size());
			sb.fail_count++;
		end
		if (sb.fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
